// ===== sv/rbmb_pkg.sv =====
// Shared types and constants for the range bit mask builder.
// Holds field widths, function and register codes, beat structs and
// the command/status structs between controller and datapath.
package rbmb_pkg;

	localparam int LANE_BITS  = 64;
	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 16;
	localparam int RCOL_W     = 7;
	localparam int RLANE_W    = 3;
	localparam int COUNT_W    = 16;
	localparam int LIFT_W     = 10;
	localparam int NCOL_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LIFT_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'd1;

	localparam logic [LIFT_W-1:0] LIFT_RESET = 10'd384;
	localparam logic [NCOL_W-1:0] NCOL_RESET = 8'd68;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [IDX_W-1:0]   range_first;
		logic [IDX_W-1:0]   range_last;
		logic [RCOL_W-1:0]  read_column;
		logic [RLANE_W-1:0] read_lane;
	} rbmb_in_t;

	typedef struct packed {
		logic [LANE_BITS-1:0] lane_data;
		logic [COUNT_W-1:0]   marked_count;
		logic                 range_error;
	} rbmb_out_t;

	typedef struct packed {
		logic load_in;   // capture the accepted input beat
		logic exec;      // decode item: clear, check range, issue lane read
		logic div_step;  // one quotient bit of the index split
		logic div_last;  // final quotient bit, load the sweep column
		logic sweep;     // read one column and build its toggle mask
		logic add_len;   // add the range length to the count
		logic load_out;  // fill the result register
	} rbmb_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              range_bad;
		logic              col_last;
	} rbmb_status_t;

endpackage

// ===== sv/range_bit_mask_builder_core.sv =====
// Clear, read, unused-function and rejected range items pass idle, exec and done; the input stalls until idle.
// Accepted range items also pass the restoring divider (one quotient bit a cycle), then one
// read-modify-write per column on the memory port in the sweep and drain states, before done.
// The result register holds a beat while the next item is accepted.
// Reset loads the configuration defaults and clears control and the per-row valid bits at once; no clearing pass.
// Depends on rbmb_pkg, rbmb_ctrl and rbmb_datapath.
module range_bit_mask_builder_core import rbmb_pkg::*; #(
	parameter int WORD_BITS = 512,
	parameter int MAX_COLS  = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rbmb_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rbmb_out_t             out_data
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	rbmb_cmd_t    cmd;
	rbmb_status_t status;

	rbmb_ctrl #(
		.COL_W(COL_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rbmb_datapath #(
		.WORD_BITS(WORD_BITS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// an accepted beat keeps the engine busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// never overwrite a result beat that is still waiting
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// a rejected range never carries lane data
	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.range_error |-> out_data.lane_data == '0)
		else $error("range error with nonzero lane data");

	// the engine only sweeps after a range that passed its checks
	a_sweep_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep && !$past(cmd.sweep) |-> $past(cmd.div_last))
		else $error("sweep started without index split");
`endif

endmodule

// ===== sv/rbmb_ctrl.sv =====
// Controller state machine of the range bit mask builder.
// Depends on rbmb_pkg for the command/status structs and function codes.
module rbmb_ctrl import rbmb_pkg::*; #(
	parameter int COL_W = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  rbmb_status_t status,
	output rbmb_cmd_t    cmd
);

	localparam int CNT_W = (COL_W > 1) ? $clog2(COL_W) : 1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_DIV   = 6'b000100,
		S_SWEEP = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.func == FUNC_RANGE && !status.range_bad) begin
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					cmd.div_last = 1'b1;
					state_d      = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.col_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last column write-back lands in this cycle
				cmd.add_len = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				cnt_q <= CNT_W'(COL_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/rbmb_datapath.sv =====
// Datapath of the range bit mask builder: config registers, index divider,
// mask memory with row valid bits, read-modify-write toggle and result register.
// Depends on rbmb_pkg for beat, command and status types.
module rbmb_datapath import rbmb_pkg::*; #(
	parameter int WORD_BITS = 512,
	parameter int MAX_COLS  = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  rbmb_in_t              in_data,
	input  rbmb_cmd_t             cmd,
	output rbmb_status_t          status,
	output rbmb_out_t             out_data
);

	localparam int LANES    = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
	localparam int PAD_BITS = LANES * LANE_BITS;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int OFF_W    = $clog2(PAD_BITS);
	localparam int LSEL_W   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int DIV_W    = (IDX_W > LIFT_W + COL_W) ? IDX_W : LIFT_W + COL_W;
	localparam int ECOL_W   = NCOL_W + 1;
	localparam int PROD_W   = ECOL_W + LIFT_W;
	localparam int LCMP_W   = ($clog2(LANES + 1) > RLANE_W) ? $clog2(LANES + 1) : RLANE_W;

	localparam logic [LIFT_W:0]     Z_MAX    = (LIFT_W + 1)'(WORD_BITS);
	localparam logic [ECOL_W-1:0]   COL_MAX  = ECOL_W'(MAX_COLS);
	localparam logic [LCMP_W-1:0]   LANE_MAX = LCMP_W'(LANES);
	localparam logic [OFF_W-1:0]    TOP_OFF  = OFF_W'(PAD_BITS - 1);
	localparam logic [PAD_BITS-1:0] ONES     = {PAD_BITS{1'b1}};

	// configuration
	logic [LIFT_W-1:0] lift_q;
	logic [NCOL_W-1:0] ncols_q;

	rbmb_in_t item_q;
	logic     err_q;
	logic     rd_ok_q;
	logic [COUNT_W-1:0] sum_q;

	logic [ECOL_W-1:0] ncols_eff;
	logic [PROD_W-1:0] bound;
	logic              range_bad;

	// index split
	logic [IDX_W-1:0] rem_first_q, rem_last_q;
	logic [DIV_W-1:0] dz_q;
	logic [COL_W-1:0] q_first_q, q_last_q;
	logic [DIV_W-1:0] rf_ext, rl_ext;
	logic             ge_first, ge_last;

	// sweep and memory
	logic [COL_W-1:0]    col_q;
	logic [COL_W-1:0]    col_s1;
	logic                wr_s1;
	logic [PAD_BITS-1:0] mask_s1;
	logic [LANES-1:0][LANE_BITS-1:0] rd_data_s1;
	logic                rvalid_s1;
	logic [PAD_BITS-1:0] mem [MAX_COLS];
	logic [MAX_COLS-1:0] valid_q;

	logic [OFF_W-1:0]    off_lo, off_hi;
	logic [PAD_BITS-1:0] mask_next;
	logic [PAD_BITS-1:0] wr_word;
	logic                rd_en;
	logic [COL_W-1:0]    rd_addr;
	logic [LSEL_W-1:0]   lane_sel;

	logic [IDX_W:0]   range_len;
	logic [IDX_W+1:0] sum_ext;

	rbmb_out_t out_q;

	assign ncols_eff = (ECOL_W'(ncols_q) > COL_MAX) ? COL_MAX : ECOL_W'(ncols_q);
	assign bound     = PROD_W'(ncols_eff) * PROD_W'(lift_q);
	assign range_bad = (lift_q == '0) || ({1'b0, lift_q} > Z_MAX)
		|| (item_q.range_first > item_q.range_last)
		|| (PROD_W'(item_q.range_last) >= bound);

	assign rf_ext   = DIV_W'(rem_first_q);
	assign rl_ext   = DIV_W'(rem_last_q);
	assign ge_first = (rf_ext >= dz_q);
	assign ge_last  = (rl_ext >= dz_q);

	// partial mask of the current column: trim at the first and last columns
	assign off_lo    = (col_q == q_first_q) ? OFF_W'(rem_first_q) : '0;
	assign off_hi    = (col_q == q_last_q) ? OFF_W'(rem_last_q) : OFF_W'(lift_q - 1'b1);
	assign mask_next = (ONES << off_lo) & (ONES >> (TOP_OFF - off_hi));

	assign wr_word  = (rvalid_s1 ? PAD_BITS'(rd_data_s1) : '0) ^ mask_s1;
	assign rd_en    = cmd.sweep || (cmd.exec && item_q.func == FUNC_READ);
	assign rd_addr  = cmd.sweep ? col_q : COL_W'(item_q.read_column);
	assign lane_sel = LSEL_W'(item_q.read_lane);

	assign range_len = {1'b0, item_q.range_last} - {1'b0, item_q.range_first} + 1'b1;
	assign sum_ext   = {2'b00, sum_q} + {1'b0, range_len};

	assign status.func      = item_q.func;
	assign status.range_bad = range_bad;
	assign status.col_last  = (col_q == q_last_q);

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_q  <= LIFT_RESET;
			ncols_q <= NCOL_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LIFT_SIZE:   lift_q  <= cfg_data[LIFT_W-1:0];
				REG_NUM_COLUMNS: ncols_q <= cfg_data[NCOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control flags, count and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q     <= 1'b0;
			rd_ok_q   <= 1'b0;
			sum_q     <= '0;
			wr_s1     <= 1'b0;
			rvalid_s1 <= 1'b0;
			valid_q   <= '0;
		end else begin
			wr_s1 <= cmd.sweep;
			if (rd_en) begin
				rvalid_s1 <= valid_q[rd_addr];
			end
			if (cmd.exec) begin
				err_q   <= (item_q.func == FUNC_RANGE) && range_bad;
				rd_ok_q <= (ECOL_W'(item_q.read_column) < COL_MAX)
					&& (LCMP_W'(item_q.read_lane) < LANE_MAX);
				if (item_q.func == FUNC_CLEAR) begin
					sum_q <= '0;
					for (int i = 0; i < MAX_COLS; i++) begin
						if (ECOL_W'(i) < ncols_eff) begin
							valid_q[i] <= 1'b0;
						end
					end
				end
			end
			if (cmd.add_len) begin
				sum_q <= (sum_ext > (IDX_W + 2)'(COUNT_MAX)) ? COUNT_MAX : sum_ext[COUNT_W-1:0];
			end
			if (wr_s1) begin
				valid_q[col_s1] <= 1'b1;
			end
		end
	end

	// payload: input capture, divider, sweep pipeline, result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			rem_first_q <= item_q.range_first;
			rem_last_q  <= item_q.range_last;
			dz_q        <= DIV_W'(lift_q) << (COL_W - 1);
			q_first_q   <= '0;
			q_last_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_first_q <= ge_first ? IDX_W'(rf_ext - dz_q) : rem_first_q;
			rem_last_q  <= ge_last ? IDX_W'(rl_ext - dz_q) : rem_last_q;
			q_first_q   <= COL_W'({q_first_q, ge_first});
			q_last_q    <= COL_W'({q_last_q, ge_last});
			dz_q        <= dz_q >> 1;
		end
		if (cmd.div_last) begin
			col_q <= COL_W'({q_first_q, ge_first});
		end else if (cmd.sweep) begin
			col_q <= col_q + 1'b1;
		end
		if (cmd.sweep) begin
			col_s1  <= col_q;
			mask_s1 <= mask_next;
		end
		if (cmd.load_out) begin
			out_q.lane_data <= (item_q.func == FUNC_READ && rd_ok_q && rvalid_s1)
				? rd_data_s1[lane_sel] : '0;
			out_q.marked_count <= sum_q;
			out_q.range_error  <= err_q;
		end
	end

	// mask memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[col_s1] <= wr_word;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

// ===== test/tb_range_bit_mask_builder_core.sv =====
// Self-checking testbench for range_bit_mask_builder_core: clear, toggle-range and lane-read beats
// are checked against an in-bench mask predictor under random sender gaps and receiver stalls.
// Depends on rbmb_pkg and the core RTL.
module tb_range_bit_mask_builder_core import rbmb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MASK_WORD_BITS = 512;
	localparam int MASK_COLS      = 128;
	localparam int DRAIN_CYCLES   = 150;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	rbmb_in_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	rbmb_out_t             out_data;

	// predictor state
	logic [MASK_WORD_BITS-1:0] mask_words [MASK_COLS];
	logic [LIFT_W-1:0]         lift_reg;
	logic [NCOL_W-1:0]         cols_reg;
	logic [COUNT_W-1:0]        marked_total;

	rbmb_out_t pending_results [$];
	rbmb_out_t want_beat;

	int err_count;
	int items_sent;
	int beats_checked;
	int cfg_writes;

	// sender pacing
	bit gaps_on;
	int burst_left;

	// receiver pattern and long hold-off
	bit          hold_go;
	bit          hold_seen;
	int unsigned hold_len;
	int unsigned hold_cnt;
	int unsigned rx_mode;
	int unsigned rx_phase;

	range_bit_mask_builder_core #(
		.WORD_BITS(MASK_WORD_BITS),
		.MAX_COLS (MASK_COLS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned active_cols();
		return (cols_reg > MASK_COLS) ? MASK_COLS : int'(cols_reg);
	endfunction

	// bits addressable by a range item; zero when the lift size is unusable
	function automatic int unsigned mask_span_bits();
		if (lift_reg == 0 || lift_reg > MASK_WORD_BITS)
			return 0;
		return active_cols() * lift_reg;
	endfunction

	function automatic rbmb_out_t predict_mask_item(rbmb_in_t it);
		rbmb_out_t   res;
		int unsigned z;
		int unsigned k;
		int unsigned sum;
		res = '0;
		z = lift_reg;
		case (it.func)
			FUNC_CLEAR: begin
				for (k = 0; k < active_cols(); k++)
					mask_words[k] = '0;
				marked_total = '0;
			end
			FUNC_RANGE: begin
				if (mask_span_bits() == 0 || it.range_first > it.range_last ||
				    it.range_last >= mask_span_bits()) begin
					res.range_error = 1'b1;
				end else begin
					for (k = it.range_first; k <= it.range_last; k++)
						mask_words[k / z][k % z] = ~mask_words[k / z][k % z];
					sum = marked_total + (it.range_last - it.range_first + 1);
					marked_total = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
				end
			end
			FUNC_READ: begin
				res.lane_data = mask_words[it.read_column][it.read_lane * LANE_BITS +: LANE_BITS];
			end
			default: ;
		endcase
		res.marked_count = marked_total;
		return res;
	endfunction

	function automatic rbmb_in_t mk_item(logic [FUNC_W-1:0] f, int unsigned first,
	                                     int unsigned last, int unsigned col, int unsigned lane);
		rbmb_in_t it;
		it.func        = f;
		it.range_first = first[IDX_W-1:0];
		it.range_last  = last[IDX_W-1:0];
		it.read_column = col[RCOL_W-1:0];
		it.read_lane   = lane[RLANE_W-1:0];
		return it;
	endfunction

	function automatic rbmb_in_t gen_mask_item();
		rbmb_in_t    it;
		int unsigned total;
		int unsigned sel;
		int unsigned span;
		int unsigned z;
		total = mask_span_bits();
		z = lift_reg;
		it = mk_item(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			it.func = FUNC_RANGE;
			if (total != 0) begin
				it.range_first = IDX_W'($urandom_range(0, total - 1));
				if ($urandom_range(0, 9) == 0) begin
					it.range_last = IDX_W'($urandom_range(it.range_first, total - 1));
				end else begin
					span = $urandom_range(1, 3 * z);
					it.range_last = (it.range_first + span - 1 >= total) ?
						IDX_W'(total - 1) : IDX_W'(it.range_first + span - 1);
				end
			end
		end else if (sel < 55) begin
			it.func = FUNC_RANGE;
			if (total <= 16'hFFFF && $urandom_range(0, 1) == 0) begin
				it.range_last  = IDX_W'($urandom_range(total, 16'hFFFF));
				it.range_first = IDX_W'($urandom_range(0, it.range_last));
			end else begin
				it.range_first = IDX_W'($urandom_range(1, 16'hFFFF));
				it.range_last  = IDX_W'($urandom_range(0, it.range_first - 1));
			end
		end else if (sel < 88) begin
			it.func = FUNC_READ;
			if (active_cols() != 0 && $urandom_range(0, 7) != 0)
				it.read_column = RCOL_W'($urandom_range(0, active_cols() - 1));
			if (z != 0 && z <= MASK_WORD_BITS && $urandom_range(0, 3) != 0)
				it.read_lane = RLANE_W'($urandom_range(0, (z - 1) / LANE_BITS));
		end else if (sel < 93) begin
			it.func = FUNC_CLEAR;
		end
		return it;
	endfunction

	task automatic send_item(input rbmb_in_t it);
		in_data  <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_mask_item(it));
		items_sent++;
	endtask

	// end a burst with a random gap
	task automatic pace_sender();
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		if (idx == REG_LIFT_SIZE)
			lift_reg = val[LIFT_W-1:0];
		else
			cols_reg = val[NCOL_W-1:0];
		cfg_writes++;
	endtask

	task automatic set_geometry(input int unsigned lift, input int unsigned cols);
		wait_idle();
		write_reg(REG_LIFT_SIZE, lift);
		write_reg(REG_NUM_COLUMNS, cols);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_reset_geometry();
		send_item(mk_item(FUNC_READ, 0, 0, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 127, 7));
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		send_item(mk_item(FUNC_RANGE, 383, 384, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 0, 5));
		send_item(mk_item(FUNC_READ, 0, 0, 1, 0));
		// last valid bit, one past the end, reversed, top of the index field
		send_item(mk_item(FUNC_RANGE, 26111, 26111, 0, 0));
		send_item(mk_item(FUNC_RANGE, 26112, 26112, 0, 0));
		send_item(mk_item(FUNC_RANGE, 10, 9, 0, 0));
		send_item(mk_item(FUNC_RANGE, 16'hFFFF, 16'hFFFF, 0, 0));
		send_item(mk_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 127, 7));
		send_item(mk_item(FUNC_CLEAR, 0, 0, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 0, 0));
	endtask

	task automatic test_geometry_extremes();
		set_geometry(1, 1);
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		send_item(mk_item(FUNC_RANGE, 0, 1, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 0, 0));
		// whole store in one range: count saturates, toggling twice restores
		set_geometry(MASK_WORD_BITS, MASK_COLS);
		send_item(mk_item(FUNC_RANGE, 0, 16'hFFFF, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 127, 7));
		send_item(mk_item(FUNC_RANGE, 0, 16'hFFFF, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 64, 3));
		send_item(mk_item(FUNC_CLEAR, 0, 0, 0, 0));
		set_geometry(0, 4);
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		set_geometry(10'h3FF, 4);
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		set_geometry(MASK_WORD_BITS + 1, 4);
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		// zero columns: clear must leave the store alone
		set_geometry(8, 4);
		send_item(mk_item(FUNC_RANGE, 0, 31, 0, 0));
		set_geometry(8, 0);
		send_item(mk_item(FUNC_RANGE, 0, 0, 0, 0));
		send_item(mk_item(FUNC_CLEAR, 0, 0, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 3, 0));
		// column count above the store size acts as the store size
		set_geometry(4, 200);
		send_item(mk_item(FUNC_RANGE, 511, 511, 0, 0));
		send_item(mk_item(FUNC_RANGE, 512, 512, 0, 0));
		set_geometry(MASK_WORD_BITS, 8'hFF);
		send_item(mk_item(FUNC_RANGE, 16'hFFFF, 16'hFFFF, 0, 0));
		send_item(mk_item(FUNC_READ, 0, 0, 127, 7));
	endtask

	task automatic test_output_backpressure();
		set_geometry(64, 16);
		gaps_on = 1'b0;
		hold_len <= 300;
		hold_go  <= ~hold_go;
		repeat (24)
			send_item(gen_mask_item());
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned lift_opts [6];
		int unsigned col_opts [6];
		int p;
		lift_opts = '{1, MASK_WORD_BITS, 384, 0, 0, 0};
		col_opts  = '{MASK_COLS, MASK_COLS, 68, 0, 0, 0};
		for (p = 3; p < 6; p++) begin
			lift_opts[p] = $urandom_range(1, MASK_WORD_BITS);
			col_opts[p]  = $urandom_range(1, MASK_COLS);
		end
		for (p = 0; p < 6; p++) begin
			set_geometry(lift_opts[p], col_opts[p]);
			gaps_on = ($urandom_range(0, 3) != 0);
			burst_left = $urandom_range(1, 12);
			repeat (125) begin
				send_item(gen_mask_item());
				pace_sender();
			end
		end
	endtask

	// receiver: long hold-off on request, otherwise one of four stall patterns, redrawn at random
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_phase % 50 == 0)
			rx_mode <= $urandom_range(0, 3);
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_cnt  <= hold_len;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= $urandom_range(0, 1);
				default: out_stall <= (rx_phase % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation: %p", out_data);
				err_count++;
			end else begin
				want_beat = pending_results.pop_front();
				beats_checked++;
				if (out_data.lane_data !== want_beat.lane_data) begin
					$error("lane_data expected %h got %h", want_beat.lane_data, out_data.lane_data);
					err_count++;
				end
				if (out_data.marked_count !== want_beat.marked_count) begin
					$error("marked_count expected %0d got %0d",
					       want_beat.marked_count, out_data.marked_count);
					err_count++;
				end
				if (out_data.range_error !== want_beat.range_error) begin
					$error("range_error expected %0b got %0b",
					       want_beat.range_error, out_data.range_error);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		lift_reg     = LIFT_RESET;
		cols_reg     = NCOL_RESET;
		marked_total = '0;
		hold_go      = 1'b0;
		hold_seen    = 1'b0;
		hold_len     = 0;
		hold_cnt     = 0;
		rx_mode      = 0;
		rx_phase     = 0;
		gaps_on      = 1'b0;
		burst_left   = 1;
		foreach (mask_words[i])
			mask_words[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_geometry_extremes();
		test_output_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected beats never arrived", pending_results.size());
			err_count++;
		end
		$display("Sent %0d items (clear, range, read, unused func) over %0d register writes,",
		         items_sent, cfg_writes);
		$display("checked %0d result beats with %0d mismatches", beats_checked, err_count);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rbmb_pkg.sv
sv/rbmb_ctrl.sv
sv/rbmb_datapath.sv
sv/range_bit_mask_builder_core.sv
test/tb_range_bit_mask_builder_core.sv
